### sv/crs_pkg.sv
// crs_pkg: widths, opcodes and derived sizes for the circle rasterizer core
// no dependencies; imported by circle_sqrt_rasterizer_core
package crs_pkg;

  localparam int CoordWidth = 10;
  localparam int DiffWidth  = CoordWidth + 1;
  localparam int R2Width    = 2 * CoordWidth + 1;
  localparam int RootWidth  = CoordWidth + 1;
  localparam int ColWidth   = CoordWidth + 1;
  localparam int NshWidth   = 2 * RootWidth;
  localparam int RemWidth   = RootWidth + 1;
  localparam int PixWidth   = 12;
  localparam int SumWidth   = (CoordWidth + 3 > PixWidth) ? CoordWidth + 3 : PixWidth;
  localparam int CntWidth   = $clog2(RootWidth);
  localparam int PointWidth = 3;

  localparam logic OpLoad = 1'b0;
  localparam logic OpStep = 1'b1;

  localparam logic [PointWidth-1:0] LastPoint = PointWidth'(7);

endpackage

### sv/circle_sqrt_rasterizer_core.sv
// circle_sqrt_rasterizer_core: circle plotter using the explicit equation and eight-way symmetry
// load: squared radius from a serial shift-add squarer, one multiplier bit per cycle;
//   no new transfer is taken until both squares are summed
// step: bit-serial square root, then 8 points, one per cycle
//   while the output is not stalled; no new transfer is taken until the eighth point is loaded
// reset: asynchronous, clears every register, comes up idle with no circle loaded
module circle_sqrt_rasterizer_core import crs_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         op_i,
  input  logic signed [CoordWidth-1:0] center_x_i,
  input  logic signed [CoordWidth-1:0] center_y_i,
  input  logic signed [CoordWidth-1:0] edge_x_i,
  input  logic signed [CoordWidth-1:0] edge_y_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [PixWidth-1:0]   pixel_x_o,
  output logic signed [PixWidth-1:0]   pixel_y_o,
  output logic                         last_o,
  output logic                         done_res_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SQRT,
    ST_EMIT
  } state_e;

  state_e                         state_q;
  logic                           active_q;
  logic                           phase_q;
  logic                           done_q;
  logic [CntWidth-1:0]            cnt_q;
  logic [PointWidth-1:0]          k_q;
  logic signed [CoordWidth-1:0]   cx_q, cy_q;
  logic [R2Width-1:0]             r2_q;
  logic [ColWidth-1:0]            col_q;
  logic [R2Width-1:0]             xx_q;
  logic [R2Width-1:0]             nxx_q;
  logic [R2Width-1:0]             mcand_q;
  logic [CoordWidth-1:0]          mplier_q;
  logic [CoordWidth-1:0]          ymag_q;
  logic [RootWidth-1:0]           root_q;
  logic [RemWidth-1:0]            rem_q;
  logic [NshWidth-1:0]            nsh_q;
  logic                           out_valid_q;
  logic signed [PixWidth-1:0]     pixel_x_q, pixel_y_q;
  logic                           last_q, done_res_q;

  logic                           in_xfer;
  logic                           out_load;
  logic signed [DiffWidth-1:0]    dx, dy;
  logic [DiffWidth-1:0]           dx_abs, dy_abs;
  logic [R2Width-1:0]             n_rem;
  logic [R2Width:0]               nxx_wide;
  logic [RemWidth+1:0]            rem_t, trial;
  logic                           take;
  logic [RootWidth-1:0]           u, v;
  logic signed [SumWidth-1:0]     a_ext, b_ext, u_ext, v_ext, sum_x, sum_y;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_load   = (state_q == ST_EMIT) && (!out_valid_q || !out_stall_i);

  // absolute differences for the squarer
  assign dx     = DiffWidth'(edge_x_i) - DiffWidth'(center_x_i);
  assign dy     = DiffWidth'(edge_y_i) - DiffWidth'(center_y_i);
  assign dx_abs = dx[DiffWidth-1] ? DiffWidth'(-dx) : DiffWidth'(dx);
  assign dy_abs = dy[DiffWidth-1] ? DiffWidth'(-dy) : DiffWidth'(dy);

  // column bookkeeping, (x+1)^2 = x^2 + 2x + 1
  assign n_rem    = r2_q - xx_q;
  assign nxx_wide = (R2Width+1)'(xx_q) + (R2Width+1)'({col_q, 1'b1});

  // one root bit per cycle
  assign rem_t = {rem_q, nsh_q[NshWidth-1 -: 2]};
  assign trial = (RemWidth+2)'({root_q, 2'b01});
  assign take  = (rem_t >= trial);

  // symmetric point selection
  assign u     = k_q[0] ? root_q : RootWidth'(col_q);
  assign v     = k_q[0] ? RootWidth'(col_q) : root_q;
  assign a_ext = SumWidth'(cx_q);
  assign b_ext = SumWidth'(cy_q);
  assign u_ext = SumWidth'(u);
  assign v_ext = SumWidth'(v);
  assign sum_x = k_q[2] ? a_ext - u_ext : a_ext + u_ext;
  assign sum_y = (k_q[2] ^ k_q[1]) ? b_ext - v_ext : b_ext + v_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      active_q    <= 1'b0;
      phase_q     <= 1'b0;
      done_q      <= 1'b0;
      cnt_q       <= '0;
      k_q         <= '0;
      cx_q        <= '0;
      cy_q        <= '0;
      r2_q        <= '0;
      col_q       <= '0;
      xx_q        <= '0;
      nxx_q       <= '0;
      mcand_q     <= '0;
      mplier_q    <= '0;
      ymag_q      <= '0;
      root_q      <= '0;
      rem_q       <= '0;
      nsh_q       <= '0;
      out_valid_q <= 1'b0;
      pixel_x_q   <= '0;
      pixel_y_q   <= '0;
      last_q      <= 1'b0;
      done_res_q  <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_xfer && op_i == OpLoad) begin
            cx_q     <= center_x_i;
            cy_q     <= center_y_i;
            r2_q     <= '0;
            mcand_q  <= R2Width'(dx_abs[CoordWidth-1:0]);
            mplier_q <= dx_abs[CoordWidth-1:0];
            ymag_q   <= dy_abs[CoordWidth-1:0];
            phase_q  <= 1'b0;
            active_q <= 1'b0;
            cnt_q    <= CntWidth'(CoordWidth - 1);
            state_q  <= ST_LOAD;
          end else if (in_xfer && op_i == OpStep && active_q) begin
            nsh_q   <= NshWidth'(n_rem);
            done_q  <= (nxx_wide > (R2Width+1)'(r2_q));
            nxx_q   <= nxx_wide[R2Width-1:0];
            root_q  <= '0;
            rem_q   <= '0;
            cnt_q   <= CntWidth'(RootWidth - 1);
            state_q <= ST_SQRT;
          end
        end

        ST_LOAD: begin
          if (mplier_q[0]) begin
            r2_q <= r2_q + mcand_q;
          end
          mcand_q  <= {mcand_q[R2Width-2:0], 1'b0};
          mplier_q <= mplier_q >> 1;
          cnt_q    <= cnt_q - 1'b1;
          if (cnt_q == '0) begin
            if (!phase_q) begin
              phase_q  <= 1'b1;
              mcand_q  <= R2Width'(ymag_q);
              mplier_q <= ymag_q;
              cnt_q    <= CntWidth'(CoordWidth - 1);
            end else begin
              active_q <= 1'b1;
              col_q    <= '0;
              xx_q     <= '0;
              state_q  <= ST_IDLE;
            end
          end
        end

        ST_SQRT: begin
          nsh_q  <= {nsh_q[NshWidth-3:0], 2'b00};
          rem_q  <= take ? RemWidth'(rem_t - trial) : rem_t[RemWidth-1:0];
          root_q <= {root_q[RootWidth-2:0], take};
          cnt_q  <= cnt_q - 1'b1;
          if (cnt_q == '0) begin
            k_q     <= '0;
            state_q <= ST_EMIT;
          end
        end

        ST_EMIT: begin
          if (out_load) begin
            pixel_x_q  <= sum_x[PixWidth-1:0];
            pixel_y_q  <= sum_y[PixWidth-1:0];
            last_q     <= (k_q == LastPoint);
            done_res_q <= done_q;
            k_q        <= k_q + 1'b1;
            if (k_q == LastPoint) begin
              state_q <= ST_IDLE;
              if (done_q) begin
                active_q <= 1'b0;
                col_q    <= '0;
              end else begin
                col_q <= col_q + 1'b1;
                xx_q  <= nxx_q;
              end
            end
          end
        end

        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign pixel_x_o   = pixel_x_q;
  assign pixel_y_o   = pixel_y_q;
  assign last_o      = last_q;
  assign done_res_o  = done_res_q;

  a_emit_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> active_q)
    else $error("emitting points without an active circle");

  a_col_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> (xx_q <= r2_q))
    else $error("column squared exceeds squared radius");

  a_load_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && op_i == OpLoad) |=> (state_q == ST_LOAD && !active_q))
    else $error("load transfer did not start the squarer");

  a_sqrt_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SQRT && cnt_q == '0) |=> (state_q == ST_EMIT && k_q == '0))
    else $error("root iteration did not hand over to point output");

  a_last_point: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && k_q == LastPoint) |=> (state_q == ST_IDLE && last_o && out_valid_o))
    else $error("eighth point not flagged as last");

endmodule

### tb/circle_sqrt_rasterizer_core_tb.sv
// circle_sqrt_rasterizer_core_tb: self-checking bench for the circle rasterizer core
// holds a point scoreboard class that predicts every plotted point from the accepted loads and steps
// depends on crs_pkg and circle_sqrt_rasterizer_core
module circle_sqrt_rasterizer_core_tb;
  import crs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  class circle_point_scoreboard;
    typedef struct packed {
      logic signed [PixWidth-1:0] px;
      logic signed [PixWidth-1:0] py;
      logic                       last;
      logic                       done;
    } point_t;

    point_t                       expected_points[$];
    logic signed [CoordWidth-1:0] ctr_x;
    logic signed [CoordWidth-1:0] ctr_y;
    logic [R2Width-1:0]           rad_sq;
    logic [ColWidth-1:0]          col;
    bit                           running;
    int                           errors;
    int                           points_seen;
    int                           loads;
    int                           active_steps;
    int                           idle_steps;
    int                           circles_done;

    function new();
      ctr_x = '0;
      ctr_y = '0;
      rad_sq = '0;
      col = '0;
      running = 1'b0;
    endfunction

    static function int radius_sq(int cx, int cy, int ex, int ey);
      int dx;
      int dy;
      dx = ex - cx;
      dy = ey - cy;
      return dx * dx + dy * dy;
    endfunction

    static function int root_floor(int n);
      int r;
      int cand;
      r = 0;
      for (int b = RootWidth; b >= 0; b--) begin
        cand = r | (1 << b);
        if (cand * cand <= n) r = cand;
      end
      return r;
    endfunction

    function int pending();
      return expected_points.size();
    endfunction

    function void add_point(int px, int py, bit last, bit done);
      point_t p;
      p.px = PixWidth'(px);
      p.py = PixWidth'(py);
      p.last = last;
      p.done = done;
      expected_points.push_back(p);
    endfunction

    function void note_input(logic op, logic signed [CoordWidth-1:0] cx,
                             logic signed [CoordWidth-1:0] cy,
                             logic signed [CoordWidth-1:0] ex,
                             logic signed [CoordWidth-1:0] ey);
      int x;
      int y;
      int a;
      int b;
      int r2;
      bit fin;
      if (op == OpLoad) begin
        ctr_x = cx;
        ctr_y = cy;
        rad_sq = R2Width'(radius_sq(int'(cx), int'(cy), int'(ex), int'(ey)));
        col = '0;
        running = 1'b1;
        loads++;
      end else if (!running) begin
        idle_steps++;
      end else begin
        active_steps++;
        x = int'(col);
        r2 = int'(rad_sq);
        y = root_floor(r2 - x * x);
        a = int'(ctr_x);
        b = int'(ctr_y);
        fin = ((x + 1) * (x + 1) > r2);
        add_point(a + x, b + y, 1'b0, fin);
        add_point(a + y, b + x, 1'b0, fin);
        add_point(a + x, b - y, 1'b0, fin);
        add_point(a + y, b - x, 1'b0, fin);
        add_point(a - x, b - y, 1'b0, fin);
        add_point(a - y, b - x, 1'b0, fin);
        add_point(a - x, b + y, 1'b0, fin);
        add_point(a - y, b + x, 1'b1, fin);
        if (fin) begin
          running = 1'b0;
          col = '0;
          circles_done++;
        end else begin
          col = col + 1'b1;
        end
      end
    endfunction

    function void check_result(logic signed [PixWidth-1:0] px, logic signed [PixWidth-1:0] py,
                               logic last, logic done);
      point_t want;
      points_seen++;
      if (expected_points.size() == 0) begin
        $error("unexpected point: pixel_x %0d pixel_y %0d last %0d done_res %0d",
               px, py, last, done);
        errors++;
        return;
      end
      want = expected_points.pop_front();
      if (px !== want.px) begin
        $error("pixel_x mismatch: expected %0d, actual %0d", want.px, px);
        errors++;
      end
      if (py !== want.py) begin
        $error("pixel_y mismatch: expected %0d, actual %0d", want.py, py);
        errors++;
      end
      if (last !== want.last) begin
        $error("last mismatch: expected %0d, actual %0d", want.last, last);
        errors++;
      end
      if (done !== want.done) begin
        $error("done_res mismatch: expected %0d, actual %0d", want.done, done);
        errors++;
      end
    endfunction
  endclass

  localparam int CoordMax = (1 << (CoordWidth - 1)) - 1;
  localparam int CoordMin = -(1 << (CoordWidth - 1));

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         in_valid_i = 1'b0;
  logic                         in_stall_o;
  logic                         op_i = OpLoad;
  logic signed [CoordWidth-1:0] center_x_i = '0;
  logic signed [CoordWidth-1:0] center_y_i = '0;
  logic signed [CoordWidth-1:0] edge_x_i = '0;
  logic signed [CoordWidth-1:0] edge_y_i = '0;
  logic                         out_valid_o;
  logic                         out_stall_i = 1'b0;
  logic signed [PixWidth-1:0]   pixel_x_o;
  logic signed [PixWidth-1:0]   pixel_y_o;
  logic                         last_o;
  logic                         done_res_o;

  circle_point_scoreboard sb = new();
  bit quiet_mode = 1'b0;
  int hold_requests = 0;

  circle_sqrt_rasterizer_core i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .op_i       (op_i),
    .center_x_i (center_x_i),
    .center_y_i (center_y_i),
    .edge_x_i   (edge_x_i),
    .edge_y_i   (edge_y_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .pixel_x_o  (pixel_x_o),
    .pixel_y_o  (pixel_y_o),
    .last_o     (last_o),
    .done_res_o (done_res_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #1000000;
    $display("circle_sqrt_rasterizer_core verification failed");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      sb.note_input(op_i, center_x_i, center_y_i, edge_x_i, edge_y_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_result(pixel_x_o, pixel_y_o, last_o, done_res_o);
    end
  end

  // output side: random stall per point, one long hold on request
  initial begin : point_sink
    int gap;
    int holds_done;
    holds_done = 0;
    forever begin
      if (hold_requests != holds_done) begin
        holds_done++;
        gap = 400;
      end else begin
        gap = quiet_mode ? 0 : int'($urandom_range(0, 17));
      end
      if (gap > 0) begin
        out_stall_i <= 1'b1;
        repeat (gap) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // valid stays high when the next transfer follows without a gap
  task automatic send_item(logic op, int cx, int cy, int ex, int ey);
    int gap;
    gap = quiet_mode ? 0 : int'($urandom_range(0, 17));
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i <= op;
    center_x_i <= CoordWidth'(cx);
    center_y_i <= CoordWidth'(cy);
    edge_x_i <= CoordWidth'(ex);
    edge_y_i <= CoordWidth'(ey);
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic drain_points();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  function automatic int rand_coord();
    return int'($urandom_range(0, (1 << CoordWidth) - 1)) + CoordMin;
  endfunction

  function automatic int edge_coord(int c, int off);
    int v;
    v = c + off;
    if (v > CoordMax || v < CoordMin) v = c - off;
    return v;
  endfunction

  task automatic send_steps(int n);
    for (int i = 0; i < n; i++) begin
      send_item(OpStep, rand_coord(), rand_coord(), rand_coord(), rand_coord());
    end
  endtask

  task automatic run_circle(int reach);
    int cx;
    int cy;
    int ex;
    int ey;
    int n;
    cx = rand_coord();
    cy = rand_coord();
    ex = edge_coord(cx, int'($urandom_range(0, 2 * reach)) - reach);
    ey = edge_coord(cy, int'($urandom_range(0, 2 * reach)) - reach);
    n = circle_point_scoreboard::root_floor(circle_point_scoreboard::radius_sq(cx, cy, ex, ey)) + 1;
    if (n > 1 && $urandom_range(0, 99) < 15) begin
      n = int'($urandom_range(1, n - 1));
    end else if ($urandom_range(0, 99) < 20) begin
      n = n + int'($urandom_range(1, 2));
    end
    send_item(OpLoad, cx, cy, ex, ey);
    send_steps(n);
  endtask

  initial begin : stimulus
    int kind;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // step with no circle loaded
    send_item(OpStep, CoordMax, CoordMin, CoordMax, CoordMin);
    // zero radius at the corner of the range
    send_item(OpLoad, CoordMin, CoordMax, CoordMin, CoordMax);
    send_steps(2);
    // largest radius, dropped by new loads while active
    send_item(OpLoad, CoordMin, CoordMin, CoordMax, CoordMax);
    send_steps(3);
    send_item(OpLoad, CoordMax, CoordMax, CoordMin, CoordMin);
    send_steps(2);
    send_item(OpLoad, 0, 0, 1, 0);
    send_steps(3);
    send_item(OpLoad, CoordMax, CoordMin, CoordMax, CoordMin + 3);
    send_steps(4);
    send_item(OpLoad, 5, 5, 6, 6);
    send_steps(2);
    drain_points();

    // long output hold while the input keeps offering steps
    hold_requests++;
    quiet_mode = 1'b1;
    send_item(OpLoad, 100, -100, 110, -100);
    send_steps(11);
    quiet_mode = 1'b0;
    drain_points();

    while (sb.loads + sb.active_steps < 370) begin
      quiet_mode = ($urandom_range(0, 7) == 0);
      kind = int'($urandom_range(0, 99));
      if (kind < 62) begin
        run_circle(12);
      end else if (kind < 70) begin
        run_circle(40);
      end else if (kind < 85) begin
        send_item(1'($urandom_range(0, 1)), rand_coord(), rand_coord(), rand_coord(),
                  rand_coord());
      end else begin
        send_item(OpLoad, rand_coord(), rand_coord(), rand_coord(), rand_coord());
        send_steps(int'($urandom_range(1, 3)));
      end
    end
    quiet_mode = 1'b0;

    drain_points();
    repeat (40) @(posedge clk_i);

    $display("covered %0d loads, %0d plotting steps, %0d steps while idle, %0d circles finished",
             sb.loads, sb.active_steps, sb.idle_steps, sb.circles_done);
    $display("checked %0d points under random stalls and one long output hold", sb.points_seen);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("circle_sqrt_rasterizer_core verification clean");
    end else begin
      $display("circle_sqrt_rasterizer_core verification failed");
    end
    $finish;
  end

endmodule
